// ----- hw/rtl/srts_pkg.sv -----
// ----------------------------------------------------------------------------
// srts_pkg: shared types and constants for signed_radix_to_symbols
// Symbol codes, config register indexes, controller states, command/status
// structs and the digit-to-symbol lookup.
// ----------------------------------------------------------------------------
package srts_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int DIGIT_SLOTS = 32;
    localparam int VALUE_W     = 32;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int SYM_W       = 8;
    localparam int TABLE_W     = 64;
    localparam int SLOT_W      = $clog2(DIGIT_SLOTS);
    localparam int COUNT_W     = 6;
    localparam int CFG_IDX_W   = 2;

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX   = 2'd0,
        CFG_SYM_LO  = 2'd1,
        CFG_SYM_HI  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [TABLE_W-1:0] sym_lo;
        logic [TABLE_W-1:0] sym_hi;
        logic               base_ok;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_sign;
        logic emit_digit;
        logic idx_dec;
    } t_cmd;

    typedef struct packed {
        logic digit_end;
        logic quo_zero;
        logic store_full;
        logic neg;
        logic idx_zero;
    } t_sts;

    function automatic logic [SYM_W-1:0] f_symbol(
        input logic [TABLE_W-1:0] lo,
        input logic [TABLE_W-1:0] hi,
        input logic [DIGIT_W-1:0] d
    );
        logic [2:0] k;
        k = d[2:0];
        if (d[3])
            return hi[k*SYM_W +: SYM_W];
        return lo[k*SYM_W +: SYM_W];
    endfunction

endpackage

// ----- hw/rtl/srts_cfg.sv -----
// ----------------------------------------------------------------------------
// srts_cfg: configuration registers and base check
// Holds radix and the symbol table; flags whether the base is usable.
// ----------------------------------------------------------------------------
module srts_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [srts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srts_pkg::TABLE_W-1:0]   i_cfg_data,
    output logic                           o_cfg_ready,
    output srts_pkg::t_cfg                 o_cfg
);
    import srts_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic [TABLE_W-1:0] r_sym_lo;
    logic [TABLE_W-1:0] r_sym_hi;
    logic               w_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= '0;
            r_sym_lo <= '0;
            r_sym_hi <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RADIX:  r_radix  <= i_cfg_data[RADIX_W-1:0];
                CFG_SYM_LO: r_sym_lo <= i_cfg_data;
                CFG_SYM_HI: r_sym_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Radix range, forbidden-symbol and pairwise checks over the symbols in use; all compares are independent.
    always_comb begin
        logic [SYM_W-1:0] s_a;
        logic             use_b;
        w_ok = (r_radix >= RADIX_W'(2)) && (r_radix <= RADIX_W'(MAX_SYMBOLS));
        for (int a = 0; a < MAX_SYMBOLS; a++) begin
            s_a = f_symbol(r_sym_lo, r_sym_hi, DIGIT_W'(a));
            if (RADIX_W'(a) < r_radix) begin
                if (s_a == '0 || s_a == SYM_PLUS || s_a == SYM_MINUS)
                    w_ok = 1'b0;
            end
            for (int b = a + 1; b < MAX_SYMBOLS; b++) begin
                use_b = RADIX_W'(b) < r_radix;
                if (use_b && (f_symbol(r_sym_lo, r_sym_hi, DIGIT_W'(b)) == s_a))
                    w_ok = 1'b0;
            end
        end
    end

    assign o_cfg.radix   = r_radix;
    assign o_cfg.sym_lo  = r_sym_lo;
    assign o_cfg.sym_hi  = r_sym_hi;
    assign o_cfg.base_ok = w_ok;

endmodule

// ----- hw/rtl/srts_ctrl.sv -----
// ----------------------------------------------------------------------------
// srts_ctrl: sequencing controller
// Steps the divider digit by digit, then walks the sign and digit symbols.
// ----------------------------------------------------------------------------
module srts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_base_ok,
    input  srts_pkg::t_sts i_sts,
    output srts_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import srts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                // invalid base: request is taken and dropped
                if (i_start && i_base_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.digit_end && (i_sts.quo_zero || i_sts.store_full))
                    n_state = i_sts.neg ? S_SIGN : S_WAIT;
            end
            S_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                n_state         = S_EMIT;
            end
            S_WAIT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_sts.idx_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_dec = 1'b1;
                    n_state       = S_WAIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/srts_dp.sv -----
// ----------------------------------------------------------------------------
// srts_dp: conversion datapath
// Radix divider (8 quotient bits per cycle), digit store and symbol output.
// ----------------------------------------------------------------------------
module srts_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  srts_pkg::t_cmd               i_cmd,
    input  srts_pkg::t_cfg               i_cfg,
    input  logic [srts_pkg::VALUE_W-1:0] i_value,
    output srts_pkg::t_sts               o_sts,
    output logic [srts_pkg::SYM_W-1:0]   o_symbol,
    output logic                         o_last
);
    import srts_pkg::*;

    logic [VALUE_W-1:0] r_mag;
    logic [DIGIT_W-1:0] r_rem;
    logic [1:0]         r_phase;
    logic               r_neg;
    logic [COUNT_W-1:0] r_cnt;
    logic [SLOT_W-1:0]  r_idx;
    logic [DIGIT_W-1:0] r_rd_data;
    logic [DIGIT_W-1:0] r_store [DIGIT_SLOTS];

    logic [VALUE_W-1:0] n_mag;
    logic [DIGIT_W-1:0] n_rem;
    logic               w_digit_end;

    // one byte of the dividend per cycle, MSB first; quotient bits shift in low
    always_comb begin
        logic [RADIX_W-1:0] t;
        logic [7:0]         q;
        n_rem = (r_phase == 2'd0) ? '0 : r_rem;
        for (int j = 0; j < 8; j++) begin
            t = {n_rem, r_mag[VALUE_W-1-j]};
            q[7-j] = (t >= i_cfg.radix);
            if (q[7-j])
                t = t - i_cfg.radix;
            n_rem = t[DIGIT_W-1:0];
        end
        n_mag = {r_mag[VALUE_W-9:0], q};
    end

    assign w_digit_end = (r_phase == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_phase <= '0;
        end else if (i_cmd.load) begin
            r_cnt   <= '0;
            r_phase <= '0;
        end else if (i_cmd.div_step) begin
            r_phase <= r_phase + 2'd1;
            if (w_digit_end)
                r_cnt <= r_cnt + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[VALUE_W-1];
            r_mag <= i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
        end else if (i_cmd.div_step) begin
            r_mag <= n_mag;
            r_rem <= n_rem;
            if (w_digit_end)
                r_idx <= r_cnt[SLOT_W-1:0];
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - SLOT_W'(1);
        end
    end

    // digit store, least significant digit at slot 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && w_digit_end)
            r_store[r_cnt[SLOT_W-1:0]] <= n_rem;
        r_rd_data <= r_store[r_idx];
    end

    assign o_sts.digit_end  = w_digit_end;
    assign o_sts.quo_zero   = (n_mag == '0);
    assign o_sts.store_full = (r_cnt == COUNT_W'(DIGIT_SLOTS - 1));
    assign o_sts.neg        = r_neg;
    assign o_sts.idx_zero   = (r_idx == '0);

    assign o_symbol = i_cmd.emit_sign ? SYM_MINUS
                                      : f_symbol(i_cfg.sym_lo, i_cfg.sym_hi, r_rd_data);
    assign o_last   = i_cmd.emit_digit && (r_idx == '0);

endmodule

// ----- hw/rtl/signed_radix_to_symbols.sv -----
// ----------------------------------------------------------------------------
// signed_radix_to_symbols: signed integer to text in a configurable base
// Converts one signed 32-bit value into a run of byte symbols.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel: write radix (index 0) and the two symbol tables
//   (indexes 1, 2) while the block is idle; o_cfg_ready is always high.
//   Request: pulse i_start with i_value while o_busy is low. If the base is
//   invalid the request is taken and nothing is sent.
//   Results: each symbol is on o_symbol/o_last for one cycle with o_strobe
//   high. A minus sign comes first for negative values, then the digits
//   most significant first; o_last marks the final one.
// Sequence, for a value with D digits (1..32):
//   The divider retires 8 quotient bits a cycle and finds the D digits
//   one after another. Each digit is then read from the store and sent;
//   a minus sign is sent during the first read. Busy lasts as long for
//   either sign; the next request is taken in the cycle busy drops.
// Reset: synchronous, active low. Config clears to zero, so the base starts
//   invalid; the controller returns to idle. The receiver cannot stall.
// ----------------------------------------------------------------------------
module signed_radix_to_symbols (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [srts_pkg::VALUE_W-1:0] i_value,
    output logic                           o_busy,
    output logic                           o_strobe,
    output logic [srts_pkg::SYM_W-1:0]     o_symbol,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [srts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srts_pkg::TABLE_W-1:0]   i_cfg_data
);
    import srts_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    srts_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    // controller: sequences divide, sign and digit phases
    srts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_base_ok (w_cfg.base_ok),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_busy    (o_busy)
    );

    // datapath: magnitude, divider, digit store, symbol lookup
    srts_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_cfg    (w_cfg),
        .i_value  (i_value),
        .o_sts    (w_sts),
        .o_symbol (o_symbol),
        .o_last   (o_last)
    );

    assign o_strobe = w_cmd.emit_sign | w_cmd.emit_digit;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for signed_radix_to_symbols
// Drives requests and base-table writes into the converter. A scoreboard
// predicts the text of every accepted value and matches each strobed symbol
// against it, in order.
// ----------------------------------------------------------------------------
module tb;
    import srts_pkg::*;

    // One expected output byte of a value's text.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_text_char;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the base registers, spells each accepted value
    // and keeps the expected symbols in arrival order.
    // ------------------------------------------------------------------------
    class t_text_scoreboard;
        logic [RADIX_W-1:0]   radix;
        logic [2*TABLE_W-1:0] table_bits;   // {symbols_high, symbols_low}
        t_text_char           expected_text[$];
        int                   mismatches;

        function new();
            radix      = '0;
            table_bits = '0;
            mismatches = 0;
        endfunction

        task report_mismatch(string what);
            $display("mismatch @%0t: %s", $realtime, what);
            mismatches++;
        endtask

        function void note_write(logic [CFG_IDX_W-1:0] idx, logic [TABLE_W-1:0] data);
            case (idx)
                CFG_RADIX:  radix = data[RADIX_W-1:0];
                CFG_SYM_LO: table_bits[TABLE_W-1:0] = data;
                CFG_SYM_HI: table_bits[2*TABLE_W-1:TABLE_W] = data;
                default:    ;   // unmapped index, write dropped
            endcase
        endfunction

        function logic [SYM_W-1:0] digit_symbol(logic [DIGIT_W-1:0] d);
            return table_bits[d*SYM_W +: SYM_W];
        endfunction

        // Base is usable only with 2..16 symbols, all nonzero, no sign
        // characters, no repeats among the symbols in use.
        function bit base_usable();
            logic [SYM_W-1:0] s;
            if (radix < 2 || radix > MAX_SYMBOLS)
                return 0;
            for (int a = 0; a < radix; a++) begin
                s = digit_symbol(a[DIGIT_W-1:0]);
                if (s == '0 || s == SYM_PLUS || s == SYM_MINUS)
                    return 0;
                for (int b = a + 1; b < radix; b++)
                    if (digit_symbol(b[DIGIT_W-1:0]) == s)
                        return 0;
            end
            return 1;
        endfunction

        function void note_request(logic signed [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] mag;
            logic [VALUE_W-1:0] base;
            logic [DIGIT_W-1:0] digits [DIGIT_SLOTS];
            int                 n;
            if (!base_usable())
                return;
            // -2^31 negates to itself, which read unsigned is the magnitude
            mag  = value[VALUE_W-1] ? (~value + 1'b1) : value;
            base = {{(VALUE_W-RADIX_W){1'b0}}, radix};
            n    = 0;
            do begin
                digits[n] = DIGIT_W'(mag % base);
                mag       = mag / base;
                n++;
            end while (mag != 0 && n < DIGIT_SLOTS);
            if (value[VALUE_W-1])
                expected_text.push_back('{sym: SYM_MINUS, last: 1'b0});
            for (int i = n - 1; i >= 0; i--)
                expected_text.push_back('{sym: digit_symbol(digits[i]), last: (i == 0)});
        endfunction

        task check_symbol(logic [SYM_W-1:0] sym, logic last);
            t_text_char want;
            if (expected_text.size() == 0) begin
                report_mismatch($sformatf("stray symbol %02h last %0b", sym, last));
            end else begin
                want = expected_text.pop_front();
                if (sym !== want.sym)
                    report_mismatch($sformatf("symbol %02h, want %02h", sym, want.sym));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", last, want.last));
            end
        endtask

        task check_drained();
            if (expected_text.size() != 0)
                report_mismatch($sformatf("%0d symbols never sent", expected_text.size()));
        endtask

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int RESET_CYCLES = 9;
    // Covers the longest busy stretch, 33 symbols worst case, plus margin.
    localparam int DRAIN_CYCLES = 6 * (DIGIT_SLOTS + 1) + 24;
    // Longest accept-free stretch: a drain pause plus a full conversion,
    // taken many times over.
    localparam int STALL_LIMIT  = 5000;
    localparam int TARGET_ITEMS = 200;
    localparam int GAP_PERCENT  = 28;
    // Index 3 is not decoded by the block; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // Handy tables: ASCII digits, and a binary set on the byte extremes.
    localparam logic [2*TABLE_W-1:0] TBL_DEC =
        {64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130};
    localparam logic [2*TABLE_W-1:0] TBL_HEX =
        {64'h6665_6463_6261_3938, 64'h3736_3534_3332_3130};
    localparam logic [2*TABLE_W-1:0] TBL_BIN =
        {64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_01FF};

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_start;
    logic signed [VALUE_W-1:0]   i_value;
    logic                        o_busy;
    logic                        o_strobe;
    logic [SYM_W-1:0]            o_symbol;
    logic                        o_last;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [TABLE_W-1:0]          i_cfg_data;

    signed_radix_to_symbols uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_value     (i_value),
        .o_busy      (o_busy),
        .o_strobe    (o_strobe),
        .o_symbol    (o_symbol),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_text_scoreboard board;
    bit               sender_steady;   // set during the no-gap stretch
    int               stall_cycles;

    initial begin
        i_clk = 1'b0;
    end
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Output monitor: the receiver never stalls, so every strobe is a result.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_symbol(o_symbol, o_last);
    end

    // ------------------------------------------------------------------------
    // Watchdog: trips after a long run of cycles with no request, no symbol
    // and no register write.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Inputs move on the falling edge, handshakes are judged
    // on the rising edge.
    // ------------------------------------------------------------------------
    function bit take_gap();
        return !sender_steady && ($urandom_range(0, 99) < GAP_PERCENT);
    endfunction

    // Hold a request until the block takes it, then drop start.
    task send_request(logic signed [VALUE_W-1:0] value);
        @(negedge i_clk);
        while (take_gap()) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        board.note_request(value);
        @(negedge i_clk);
        i_start <= 1'b0;
        i_value <= $urandom;     // junk while no request is up
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [TABLE_W-1:0] data);
        @(negedge i_clk);
        while (take_gap()) begin
            i_cfg_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        board.note_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= {$urandom, $urandom};
    endtask

    task wait_results();
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    // Registers only change once the block is quiet. A request on a bad base
    // leaves nothing to wait for, so a full conversion time is let pass too.
    task wait_quiet();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
    endtask

    // Load radix and both tables; radix goes in the low bits, the upper data bits are random.
    task load_base(logic [RADIX_W-1:0] radix, logic [2*TABLE_W-1:0] tbl);
        logic [TABLE_W-1:0] radix_word;
        radix_word = {$urandom, $urandom};
        radix_word[RADIX_W-1:0] = radix;
        wait_quiet();
        write_reg(CFG_RADIX, radix_word);
        write_reg(CFG_SYM_LO, tbl[TABLE_W-1:0]);
        write_reg(CFG_SYM_HI, tbl[2*TABLE_W-1:TABLE_W]);
    endtask

    function logic [2*TABLE_W-1:0] put_symbol(logic [2*TABLE_W-1:0] tbl, int k,
                                              logic [SYM_W-1:0] s);
        tbl[k*SYM_W +: SYM_W] = s;
        return tbl;
    endfunction

    // Sixteen distinct legal symbols, so any radix up to 16 is usable.
    function automatic logic [2*TABLE_W-1:0] random_table();
        logic [2*TABLE_W-1:0] tbl;
        logic [SYM_W-1:0]     s;
        bit                   taken [256];
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            do
                s = SYM_W'($urandom_range(1, 255));
            while (s == SYM_PLUS || s == SYM_MINUS || taken[s]);
            taken[s] = 1'b1;
            tbl[k*SYM_W +: SYM_W] = s;
        end
        return tbl;
    endfunction

    // Value mix: full random, near zero, extremes, digit-count boundaries.
    function logic signed [VALUE_W-1:0] random_value(logic [RADIX_W-1:0] radix);
        logic [63:0]               pw;
        logic signed [VALUE_W-1:0] v;
        int                        k;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 40) - 20;
            1: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = -1;
                    3: v = 1;
                    default: v = 0;
                endcase
            end
            2, 3: begin
                // radix^k - 1, radix^k or radix^k + 1, either sign
                pw = 1;
                k  = $urandom_range(0, 31);
                while (k > 0 && radix > 1 && pw * radix <= 64'h8000_0000) begin
                    pw = pw * radix;
                    k--;
                end
                v = VALUE_W'(pw + $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            4: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [2*TABLE_W-1:0] tbl;
        logic [RADIX_W-1:0]   radix;
        bit                   broken;
        int                   counted;
        int                   phase;
        int                   n_items;

        board         = new();
        sender_steady = 1'b0;
        stall_cycles  = 0;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_value       = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_RADIX;
        i_cfg_data    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Out of reset radix is 0: request is taken, nothing comes back.
        send_request(32'sd77);

        // Decimal: zero, unit values, both extremes, digit-count edges.
        load_base(5'd10, TBL_DEC);
        send_request(0);
        send_request(1);
        send_request(-1);
        send_request(32'sh7FFF_FFFF);
        send_request(32'sh8000_0000);
        send_request(-10);
        send_request(9);
        send_request(32'sd1000000000);

        // Binary on 0xFF / 0x01 symbols: most negative value gives the
        // longest text, sign plus 32 digits.
        load_base(5'd2, TBL_BIN);
        send_request(32'sh8000_0000);
        send_request(-1);
        send_request(32'sh7FFF_FFFF);

        // Hex uses every table slot.
        load_base(5'd16, TBL_HEX);
        send_request(32'shDEAD_BEEF);
        send_request(32'sh0123_4567);
        send_request(32'sh8000_0000);

        // Broken bases: each request must be silently swallowed.
        load_base(5'd1, TBL_HEX);                              // radix too small
        send_request(-12345);
        load_base(5'd17, TBL_HEX);                             // radix too large
        send_request(-12345);
        wait_quiet();
        write_reg(CFG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF);         // radix reads 31
        send_request(-12345);
        load_base(5'd10, put_symbol(TBL_DEC, 3, SYM_PLUS));    // plus in use
        send_request(-12345);
        load_base(5'd10, put_symbol(TBL_DEC, 5, SYM_MINUS));   // minus in use
        send_request(-12345);
        load_base(5'd10, put_symbol(TBL_DEC, 0, 8'h00));       // null symbol
        send_request(-12345);
        load_base(5'd10, put_symbol(TBL_DEC, 9, 8'h32));       // repeated symbol
        send_request(-12345);

        // Unmapped index must not disturb a good decimal base.
        load_base(5'd10, TBL_DEC);
        wait_quiet();
        write_reg(CFG_UNMAPPED, 64'h0000_0000_0000_0000);
        send_request(-2024);

        // Random part: a fresh base per phase, mostly usable ones.
        counted = 0;
        phase   = 0;
        while (counted < TARGET_ITEMS) begin
            sender_steady = (phase == 3 || phase == 4);
            broken        = (phase > 1) && ($urandom_range(0, 5) == 0);
            tbl           = random_table();
            if (phase == 0)
                radix = 5'd2;
            else if (phase == 1)
                radix = 5'd16;
            else
                radix = RADIX_W'($urandom_range(2, MAX_SYMBOLS));
            if (broken) begin
                case ($urandom_range(0, 4))
                    0: radix = ($urandom_range(0, 1)) ? RADIX_W'($urandom_range(0, 1))
                                                      : RADIX_W'($urandom_range(17, 31));
                    1: tbl = put_symbol(tbl, $urandom_range(0, radix - 1), 8'h00);
                    2: tbl = put_symbol(tbl, $urandom_range(0, radix - 1), SYM_PLUS);
                    3: tbl = put_symbol(tbl, $urandom_range(0, radix - 1), SYM_MINUS);
                    default: tbl = put_symbol(tbl, $urandom_range(1, radix - 1),
                                              tbl[SYM_W-1:0]);
                endcase
            end else if ($urandom_range(0, 1)) begin
                // junk, even nulls and signs, in slots past the radix is fine
                for (int k = radix; k < MAX_SYMBOLS; k++)
                    tbl = put_symbol(tbl, k, SYM_W'($urandom));
            end
            load_base(radix, tbl);
            n_items = broken ? 4 : 20;
            for (int i = 0; i < n_items; i++) begin
                // sometimes hold the next request until the text is all out
                if ((phase == 2 && i == 10) || (!sender_steady && $urandom_range(0, 19) == 0))
                    wait_results();
                send_request(random_value(radix));
                if (!broken)
                    counted++;
            end
            phase++;
        end

        sender_steady = 1'b0;
        wait_quiet();
        board.check_drained();
        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
